// ===== rtl/stereo_feedback_delay_svf_macros.svh =====
// Assertion macros for the stereo feedback delay.
`ifndef STEREO_FEEDBACK_DELAY_SVF_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_SVF_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define SFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfd: same-cycle check failed");
// Next-cycle implication.
`define SFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfd: next-cycle check failed");
`else
`define SFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/sfd_pkg.sv =====
// Shared types, constants and helper functions of the stereo feedback delay.
package sfd_pkg;

	localparam int SW            = 24;
	localparam int FRAC          = SW - 1;
	localparam int FW            = SW + 8;
	localparam int GW            = 18;
	localparam int PW            = FW + GW + 1;
	localparam int EW            = 56;
	localparam int LEN_BITS      = 19;
	localparam int SEL_BITS      = 2;
	localparam int CFG_IDX_BITS  = 4;
	localparam int CFG_DATA_BITS = 19;
	localparam int TAB_SIZE      = 1024;
	localparam int TAB_IW        = 10;
	localparam int TAB_AW        = TAB_IW + 1;
	localparam int TAB_SHIFT     = FRAC - 6;
	localparam int DELAY_DEPTH_DEF = 262144;

	localparam logic [63:0] EXP_STEP  = 64'd2114190001;
	localparam logic [63:0] SMP_MAX_U = (64'd1 << FRAC) - 64'd1;

	localparam logic signed [EW-1:0] SMP_HI = (EW'(1) <<< FRAC) - EW'(1);
	localparam logic signed [EW-1:0] SMP_LO = -(EW'(1) <<< FRAC);
	localparam logic signed [EW-1:0] FLT_HI = (EW'(1) <<< (FW - 1)) - EW'(1);
	localparam logic signed [EW-1:0] FLT_LO = -(EW'(1) <<< (FW - 1));
	localparam logic signed [EW-1:0] HALF16 = EW'(1) <<< 15;
	localparam logic signed [EW-1:0] HALF17 = EW'(1) <<< 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_LEN  = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_LEN = 4'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WET       = 4'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DRY       = 4'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_FB        = 4'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_FREQ      = 4'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_DAMP      = 4'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SELECT    = 4'd7;

	localparam logic [SEL_BITS-1:0] SEL_LOW  = 2'd0;
	localparam logic [SEL_BITS-1:0] SEL_HIGH = 2'd1;
	localparam logic [SEL_BITS-1:0] SEL_BAND = 2'd2;

	localparam logic [GW-1:0] FREQ_RESET = 18'd4886;

	typedef logic signed [SW-1:0] smp_t;
	typedef logic signed [FW-1:0] flt_t;
	typedef logic [GW-1:0] gain_t;
	typedef logic [SW-1:0] clip_tab_t [0:TAB_SIZE];

	typedef struct packed {
		gain_t                wet;
		gain_t                dry;
		gain_t                fb;
		gain_t                freq;
		gain_t                damp;
		logic [SEL_BITS-1:0]  sel;
	} coef_t;

	typedef struct packed {
		logic start;
		logic ack;
	} chan_ctl_t;

	typedef struct packed {
		logic ready;
		logic done;
	} chan_sts_t;

	function automatic smp_t sat_smp(input logic signed [EW-1:0] v);
		if (v > SMP_HI)
			return SMP_HI[SW-1:0];
		else if (v < SMP_LO)
			return SMP_LO[SW-1:0];
		return v[SW-1:0];
	endfunction

	function automatic flt_t sat_flt(input logic signed [EW-1:0] v);
		if (v > FLT_HI)
			return FLT_HI[FW-1:0];
		else if (v < FLT_LO)
			return FLT_LO[FW-1:0];
		return v[FW-1:0];
	endfunction

	// Soft clip curve tanh(y/2), entry k at y = k/64, built at elaboration.
	function automatic clip_tab_t build_clip_tab();
		clip_tab_t   tab;
		logic [63:0] e;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] n;
		logic [63:0] q;
		logic [63:0] r;
		e = 64'd1 << 31;
		for (int k = 0; k <= TAB_SIZE; k++) begin
			num = (64'd1 << 31) - e;
			den = (64'd1 << 31) + e;
			n   = (num << FRAC) + (den >> 1);
			q   = '0;
			r   = '0;
			for (int i = 63; i >= 0; i--) begin
				r = {r[62:0], n[i]};
				if (r >= den) begin
					r    = r - den;
					q[i] = 1'b1;
				end
			end
			tab[k] = (q > SMP_MAX_U) ? SMP_MAX_U[SW-1:0] : q[SW-1:0];
			e = (e * EXP_STEP + (64'd1 << 30)) >> 31;
		end
		return tab;
	endfunction

endpackage

// ===== rtl/sfd_in_if.sv =====
// Input channel: one stereo sample request.
interface sfd_in_if;
	import sfd_pkg::*;
	logic valid;
	logic ready;
	smp_t left_in;
	smp_t right_in;
	modport source(output valid, output left_in, output right_in, input ready);
	modport sink(input valid, input left_in, input right_in, output ready);
endinterface

// ===== rtl/sfd_out_if.sv =====
// Output channel: one stereo result request.
interface sfd_out_if;
	import sfd_pkg::*;
	logic valid;
	logic ready;
	smp_t left_out;
	smp_t right_out;
	modport source(output valid, output left_out, output right_out, input ready);
	modport sink(input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/stereo_feedback_delay_svf.sv =====
// Top level of the stereo feedback delay with filtered, soft-clipped feedback.
// An accepted request yields a result request after the per-channel sequence around one shared
// multiplier and the delay memory; a new stereo pair is taken only after the last one is released.
// Reset clears positions, filter state and registers, then sweeps both delay memories to zero
// with input ready low; a length write holds ready low while the position is wrapped.
`include "stereo_feedback_delay_svf_macros.svh"

module stereo_feedback_delay_svf #(
	parameter int DELAY_DEPTH = sfd_pkg::DELAY_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	sfd_in_if.sink                              in_ch,
	sfd_out_if.source                           out_ch,
	input  logic                                cfg_we,
	input  logic [sfd_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  logic [sfd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import sfd_pkg::*;

	localparam int LW = $clog2(DELAY_DEPTH + 1);

	coef_t         coef_q;
	logic [LW-1:0] len_fit;
	logic          l_len_we;
	logic          r_len_we;
	chan_ctl_t     ctl;
	chan_sts_t     l_sts;
	chan_sts_t     r_sts;
	smp_t          l_y;
	smp_t          r_y;
	logic          out_load;
	logic          out_valid_q;
	smp_t          left_out_q;
	smp_t          right_out_q;

	// Length write: zero acts as one, anything past the memory saturates to its depth.
	always_comb begin
		if (cfg_data[LEN_BITS-1:0] == '0)
			len_fit = LW'(1);
		else if (32'(cfg_data[LEN_BITS-1:0]) > 32'(DELAY_DEPTH))
			len_fit = LW'(DELAY_DEPTH);
		else
			len_fit = LW'(cfg_data[LEN_BITS-1:0]);
	end

	assign l_len_we = cfg_we && (cfg_idx == REG_LEFT_LEN);
	assign r_len_we = cfg_we && (cfg_idx == REG_RIGHT_LEN);

	// Gain and filter registers; unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.wet  <= '0;
			coef_q.dry  <= '0;
			coef_q.fb   <= '0;
			coef_q.freq <= FREQ_RESET;
			coef_q.damp <= '0;
			coef_q.sel  <= SEL_LOW;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WET:    coef_q.wet  <= cfg_data[GW-1:0];
				REG_DRY:    coef_q.dry  <= cfg_data[GW-1:0];
				REG_FB:     coef_q.fb   <= cfg_data[GW-1:0];
				REG_FREQ:   coef_q.freq <= cfg_data[GW-1:0];
				REG_DAMP:   coef_q.damp <= cfg_data[GW-1:0];
				REG_SELECT: coef_q.sel  <= cfg_data[SEL_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Both channels run the same fixed sequence, so they start and finish together.
	assign in_ch.ready = l_sts.ready && r_sts.ready;
	assign ctl.start   = in_ch.valid && in_ch.ready;

	// Move a finished pair into the output register once it is free; release the channels.
	assign out_load = l_sts.done && r_sts.done && (!out_valid_q || out_ch.ready);
	assign ctl.ack  = out_load;

	sfd_chan #(
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (coef_q),
		.len_we  (l_len_we),
		.len_val (len_fit),
		.ctl     (ctl),
		.sts     (l_sts),
		.x       (in_ch.left_in),
		.y       (l_y)
	);

	sfd_chan #(
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (coef_q),
		.len_we  (r_len_we),
		.len_val (len_fit),
		.ctl     (ctl),
		.sts     (r_sts),
		.x       (in_ch.right_in),
		.y       (r_y)
	);

	// Output register: hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_out_q  <= l_y;
			right_out_q <= r_y;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.left_out  = left_out_q;
	assign out_ch.right_out = right_out_q;

	`SFD_ASSERT_NXT(a_take_busy, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
	`SFD_ASSERT_IMP(a_lockstep, clk, arst_n, 1'b1, l_sts.done == r_sts.done)
	`SFD_ASSERT_NXT(a_release, clk, arst_n, out_load, !l_sts.done && out_ch.valid)

endmodule

// ===== rtl/sfd_clip.sv =====
// Soft clip curve ROM with two registered read ports.
module sfd_clip (
	input  logic                       clk,
	input  logic [sfd_pkg::TAB_AW-1:0] addr0,
	input  logic [sfd_pkg::TAB_AW-1:0] addr1,
	output logic [sfd_pkg::SW-1:0]     q0,
	output logic [sfd_pkg::SW-1:0]     q1
);
	import sfd_pkg::*;

	localparam clip_tab_t TAB = build_clip_tab();

	always_ff @(posedge clk) begin
		q0 <= TAB[addr0];
		q1 <= TAB[addr1];
	end

endmodule

// ===== rtl/sfd_chan.sv =====
// One channel: delay memory, shared multiplier sequencer, filter and soft clip.
module sfd_chan #(
	parameter int DELAY_DEPTH = sfd_pkg::DELAY_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sfd_pkg::coef_t                         coef,
	input  logic                                   len_we,
	input  logic [$clog2(DELAY_DEPTH + 1)-1:0]     len_val,
	input  sfd_pkg::chan_ctl_t                     ctl,
	output sfd_pkg::chan_sts_t                     sts,
	input  sfd_pkg::smp_t                          x,
	output sfd_pkg::smp_t                          y
);
	import sfd_pkg::*;

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int LW = $clog2(DELAY_DEPTH + 1);
	localparam int CW = $clog2(AW + 1);

	localparam logic [4:0] ST_CLR  = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] ST_TAP  = 5'd2;
	localparam logic [4:0] ST_M1   = 5'd3;
	localparam logic [4:0] ST_M2   = 5'd4;
	localparam logic [4:0] ST_M3   = 5'd5;
	localparam logic [4:0] ST_P1   = 5'd6;
	localparam logic [4:0] ST_P2   = 5'd7;
	localparam logic [4:0] ST_P3   = 5'd8;
	localparam logic [4:0] ST_P4   = 5'd9;
	localparam logic [4:0] ST_P5   = 5'd10;
	localparam logic [4:0] ST_P6   = 5'd11;
	localparam logic [4:0] ST_AVG  = 5'd12;
	localparam logic [4:0] ST_SC1  = 5'd13;
	localparam logic [4:0] ST_SC2  = 5'd14;
	localparam logic [4:0] ST_SC3  = 5'd15;
	localparam logic [4:0] ST_DONE = 5'd16;

	logic [4:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic              pass_q;
	logic [AW-1:0]     pos_q;
	logic [LW-1:0]     len_q;
	flt_t              low_q;
	flt_t              band_q;

	logic              mod_busy_q;
	logic [CW-1:0]     mod_cnt_q;
	logic [AW-1:0]     num_q;
	logic [LW-1:0]     rem_q;
	logic [LW-1:0]     div_q;
	logic              pend_q;
	logic [LW-1:0]     pend_len_q;

	smp_t              x_q;
	smp_t              tap_q;
	logic signed [PW-1:0] sum_q;
	smp_t              y_q;
	smp_t              f_q;
	flt_t              notch_q;
	flt_t              high_q;
	logic signed [FW:0] acc_q;
	flt_t              v_q;
	logic              neg_q;
	logic [TAB_SHIFT-1:0] fr_q;
	smp_t              tb0_q;

	logic [SW-1:0]     mem [DELAY_DEPTH];
	logic [SW-1:0]     rdata_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [SW-1:0]     mem_wdata;

	flt_t              mul_a;
	gain_t             mul_b;
	logic signed [PW-1:0] prod_s1;

	logic signed [EW-1:0] prod_x;
	logic signed [EW-1:0] prod_r16;
	logic signed [EW-1:0] prod_r17;
	logic signed [EW-1:0] sum_r16;
	logic signed [EW-1:0] sc_r;
	logic signed [EW-1:0] sc_w;
	logic signed [FW+1:0] avg_w;
	flt_t              pick;

	logic [FW-1:0]     abs_w;
	logic              big_w;
	logic [TAB_AW-1:0] rom_a0;
	logic [TAB_AW-1:0] rom_a1;
	logic [SW-1:0]     rom_q0;
	logic [SW-1:0]     rom_q1;
	logic [SW-1:0]     tab_d;

	logic [LW:0]       mod_t;
	logic [LW-1:0]     rem_nx;
	logic              start_pend;
	logic [AW-1:0]     pos_inc;

	// Delay memory: one write port, one registered read port at the position.
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[pos_q];
	end

	sfd_clip u_clip (
		.clk   (clk),
		.addr0 (rom_a0),
		.addr1 (rom_a1),
		.q0    (rom_q0),
		.q1    (rom_q1)
	);

	// Shared multiplier, product registered.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_TAP: begin
				mul_a = FW'(x_q);
				mul_b = coef.dry;
			end
			ST_M1: begin
				mul_a = FW'(tap_q);
				mul_b = coef.wet;
			end
			ST_M2: begin
				mul_a = FW'(tap_q);
				mul_b = coef.fb;
			end
			ST_M3, ST_P6: begin
				mul_a = band_q;
				mul_b = coef.damp;
			end
			ST_P1: begin
				mul_a = band_q;
				mul_b = coef.freq;
			end
			ST_P4: begin
				mul_a = high_q;
				mul_b = coef.freq;
			end
			ST_SC2: begin
				mul_a = FW'(tab_d);
				mul_b = GW'(fr_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk)
		prod_s1 <= mul_a * $signed({1'b0, mul_b});

	assign prod_x   = EW'(prod_s1);
	assign prod_r16 = (prod_x + HALF16) >>> 16;
	assign prod_r17 = (prod_x + HALF17) >>> 17;
	assign sum_r16  = (EW'(sum_q) + prod_x + HALF16) >>> 16;
	assign avg_w    = ((FW + 2)'(acc_q) + (FW + 2)'(1)) >>> 1;
	assign tab_d    = rom_q1 - rom_q0;
	assign sc_r     = EW'(tb0_q) + prod_r17;
	assign sc_w     = neg_q ? -sc_r : sc_r;

	always_comb begin
		unique case (coef.sel)
			SEL_LOW:  pick = low_q;
			SEL_HIGH: pick = high_q;
			SEL_BAND: pick = band_q;
			default:  pick = '0;
		endcase
	end

	// Soft clip table addressing: magnitude, segment and fraction.
	assign abs_w  = v_q[FW-1] ? (~v_q + FW'(1)) : v_q;
	assign big_w  = |abs_w[FW-1:TAB_SHIFT+TAB_IW];
	assign rom_a0 = big_w ? TAB_AW'(TAB_SIZE) : {1'b0, abs_w[TAB_SHIFT+TAB_IW-1:TAB_SHIFT]};
	assign rom_a1 = big_w ? TAB_AW'(TAB_SIZE)
	                      : {1'b0, abs_w[TAB_SHIFT+TAB_IW-1:TAB_SHIFT]} + TAB_AW'(1);

	assign mem_we    = (state_q == ST_CLR) || (state_q == ST_SC3);
	assign mem_waddr = (state_q == ST_CLR) ? clr_q : pos_q;
	assign mem_wdata = (state_q == ST_CLR) ? '0 : sc_w[SW-1:0];

	assign pos_inc = pos_q + AW'(1);

	// Remainder step for a length change, one bit a cycle.
	assign mod_t      = {rem_q, num_q[AW-1]};
	assign rem_nx     = (mod_t >= {1'b0, div_q}) ? LW'(mod_t - {1'b0, div_q}) : mod_t[LW-1:0];
	assign start_pend = !mod_busy_q && pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			pass_q     <= 1'b0;
			pos_q      <= '0;
			len_q      <= LW'(1);
			low_q      <= '0;
			band_q     <= '0;
			mod_busy_q <= 1'b0;
			mod_cnt_q  <= '0;
			num_q      <= '0;
			rem_q      <= '0;
			div_q      <= LW'(1);
			pend_q     <= 1'b0;
			pend_len_q <= LW'(1);
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DELAY_DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: if (ctl.start) state_q <= ST_TAP;
				ST_TAP:  state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3: begin
					pass_q  <= 1'b0;
					state_q <= ST_P1;
				end
				ST_P1: state_q <= ST_P2;
				ST_P2: begin
					low_q   <= sat_flt(EW'(low_q) + prod_r16);
					state_q <= ST_P3;
				end
				ST_P3: state_q <= ST_P4;
				ST_P4: state_q <= ST_P5;
				ST_P5: begin
					band_q  <= sat_flt(prod_r16 + EW'(band_q));
					state_q <= ST_P6;
				end
				ST_P6: begin
					pass_q  <= 1'b1;
					state_q <= pass_q ? ST_AVG : ST_P1;
				end
				ST_AVG: state_q <= ST_SC1;
				ST_SC1: state_q <= ST_SC2;
				ST_SC2: state_q <= ST_SC3;
				ST_SC3: begin
					pos_q   <= ((LW'(pos_q) + LW'(1)) >= len_q) ? '0 : pos_inc;
					state_q <= ST_DONE;
				end
				ST_DONE: if (ctl.ack) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase

			// Wrap the position into a new length.
			if (mod_busy_q) begin
				num_q     <= num_q << 1;
				rem_q     <= rem_nx;
				mod_cnt_q <= mod_cnt_q - CW'(1);
				if (mod_cnt_q == CW'(1)) begin
					pos_q      <= rem_nx[AW-1:0];
					mod_busy_q <= 1'b0;
				end
			end else if (start_pend) begin
				num_q      <= pos_q;
				rem_q      <= '0;
				div_q      <= pend_len_q;
				mod_cnt_q  <= CW'(AW);
				mod_busy_q <= 1'b1;
				pend_q     <= 1'b0;
			end

			if (len_we) begin
				len_q <= len_val;
				if (!mod_busy_q && !pend_q) begin
					num_q      <= pos_q;
					rem_q      <= '0;
					div_q      <= len_val;
					mod_cnt_q  <= CW'(AW);
					mod_busy_q <= 1'b1;
				end else if (!pend_q || start_pend || len_val < pend_len_q) begin
					// a larger length after a pending one leaves the remainder as it is
					pend_q     <= 1'b1;
					pend_len_q <= len_val;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: x_q <= x;
			ST_TAP:  tap_q <= rdata_q;
			ST_M1:   sum_q <= prod_s1;
			ST_M2:   y_q <= sat_smp(sum_r16);
			ST_M3: begin
				f_q   <= sat_smp(prod_r16 + EW'(x_q));
				acc_q <= '0;
			end
			ST_P1:  notch_q <= sat_flt(EW'(f_q) - prod_r16);
			ST_P3:  high_q <= sat_flt(EW'(notch_q) - EW'(low_q));
			ST_P6:  acc_q <= acc_q + (FW + 1)'(pick);
			ST_AVG: v_q <= avg_w[FW-1:0];
			ST_SC1: begin
				neg_q <= v_q[FW-1];
				fr_q  <= big_w ? '0 : abs_w[TAB_SHIFT-1:0];
			end
			ST_SC2: tb0_q <= rom_q0;
			default: begin
			end
		endcase
	end

	assign sts.ready = (state_q == ST_IDLE) && !mod_busy_q && !pend_q;
	assign sts.done  = (state_q == ST_DONE);
	assign y         = y_q;

endmodule
